>>> design/assert_macros.svh
// Assertion helpers for the design files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/slps_pkg.sv
// ----------------------------------------------------------------------------
// Status LED pattern sequencer package
// Shared types, codes, sizes and the colour and timing functions.
// ----------------------------------------------------------------------------
`default_nettype none

package slps_pkg;

   // Request FIFO sizing.
   localparam int FIFO_DEPTH = 10;
   localparam int FIFO_IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Configuration port sizing and register indexes.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_BREATH_STEP = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POLL_WAIT   = 1'b1;

   localparam logic [7:0] BREATH_STEP_RESET = 8'd3;
   localparam logic [7:0] POLL_WAIT_RESET   = 8'd10;

   // Operation codes of an input transaction.
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   // Status modes; any other code means LED off.
   typedef logic [2:0] mode_type;
   localparam mode_type MODE_BOOT       = 3'd0;
   localparam mode_type MODE_CONNECTING = 3'd1;
   localparam mode_type MODE_CONNECTED  = 3'd2;
   localparam mode_type MODE_BUSY       = 3'd3;
   localparam mode_type MODE_ERROR      = 3'd4;
   localparam mode_type MODE_IDLE       = 3'd5;

   typedef logic [7:0] level_type;
   typedef logic [7:0] ticks_type;
   typedef logic [8:0] step_type;

   typedef struct packed {
      level_type red;
      level_type green;
      level_type blue;
   } colour_type;

   localparam colour_type COLOUR_OFF    = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
   localparam colour_type COLOUR_YELLOW = '{red: 8'd255, green: 8'd255, blue: 8'd0};
   localparam colour_type COLOUR_GREEN  = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
   localparam colour_type COLOUR_CYAN   = '{red: 8'd0,   green: 8'd255, blue: 8'd255};
   localparam colour_type COLOUR_RED    = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
   localparam colour_type COLOUR_PURPLE = '{red: 8'd20,  green: 8'd0,   blue: 8'd20};

   // Segment timing.
   localparam ticks_type CONNECT_SEG_TICKS = 8'd250;
   localparam ticks_type BLINK_SEG_TICKS   = 8'd100;
   localparam ticks_type TIMER_MAX         = 8'd255;
   localparam step_type  BREATH_LAST_STEP  = 9'd511;

   // Classified transaction held in the queue between front and back.
   typedef struct packed {
      logic     is_request;
      mode_type mode;
   } item_type;

   // Sequencer status seen by the top level.
   typedef struct packed {
      logic [FIFO_CNT_W-1:0] fifo_count;
      logic                  running;
   } seq_status_type;

   // Length of one segment of the given mode in ticks.
   function automatic ticks_type seg_len(input mode_type mode, input ticks_type breath_step);
      ticks_type len;
      case (mode)
         MODE_BOOT:       len = (breath_step == '0) ? 8'd1 : breath_step;
         MODE_CONNECTING: len = CONNECT_SEG_TICKS;
         default:         len = BLINK_SEG_TICKS;
      endcase
      return len;
   endfunction

   // True when the given step is the last segment of the mode's sequence.
   function automatic logic last_seg(input mode_type mode, input step_type step);
      logic last;
      case (mode)
         MODE_BOOT:       last = (step == BREATH_LAST_STEP);
         MODE_CONNECTING,
         MODE_BUSY,
         MODE_ERROR:      last = (step == 9'd1);
         default:         last = (step == 9'd0);
      endcase
      return last;
   endfunction

   // Colour of a segment. The breathing ramp scales full blue by level/255,
   // which is the level itself: up over the first half, down over the second.
   function automatic colour_type seg_colour(input mode_type mode, input step_type step);
      colour_type col;
      col = COLOUR_OFF;
      case (mode)
         MODE_BOOT:       col.blue = step[8] ? ~step[7:0] : step[7:0];
         MODE_CONNECTING: col = (step == '0) ? COLOUR_YELLOW : COLOUR_OFF;
         MODE_CONNECTED:  col = COLOUR_GREEN;
         MODE_BUSY:       col = (step == '0) ? COLOUR_CYAN : COLOUR_OFF;
         MODE_ERROR:      col = (step == '0) ? COLOUR_RED : COLOUR_OFF;
         MODE_IDLE:       col = COLOUR_PURPLE;
         default:         col = COLOUR_OFF;
      endcase
      return col;
   endfunction

endpackage

`default_nettype wire

>>> design/slps_ifs.sv
// ----------------------------------------------------------------------------
// Status LED pattern sequencer channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

// Input channel: ticks and mode requests.
interface slps_req_if;
   logic                 valid;
   logic                 ready;
   logic                 op;
   slps_pkg::mode_type   requested_mode;

   modport source (output valid, output op, output requested_mode, input ready);
   modport sink   (input valid, input op, input requested_mode, output ready);
endinterface

// Result channel: LED colour and refusal flag.
interface slps_rsp_if;
   logic                 valid;
   logic                 ready;
   slps_pkg::level_type  red;
   slps_pkg::level_type  green;
   slps_pkg::level_type  blue;
   logic                 request_refused;

   modport source (output valid, output red, output green, output blue,
                   output request_refused, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input request_refused, output ready);
endinterface

// Register write channel.
interface slps_csr_if;
   logic                                valid;
   logic                                ready;
   logic [slps_pkg::CSR_IDX_W-1:0]      index;
   logic [slps_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/slps_front.sv
// ----------------------------------------------------------------------------
// Status LED pattern sequencer front end
// Accepts input transactions, classifies them and holds them in a
// two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module slps_front (
   input  wire logic              clock,
   input  wire logic              reset,
   slps_req_if.sink               req_if,
   output slps_pkg::item_type     q_item,
   output logic                   q_valid,
   input  wire logic              q_pop
);
   import slps_pkg::*;

   item_type   queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   new_item;

   // Classify the incoming transaction.
   always_comb begin
      new_item.is_request = (req_if.op == OP_REQUEST);
      new_item.mode       = req_if.requested_mode;
   end

   assign req_if.ready = (count_ff != 2'd2);
   assign push         = req_if.valid && req_if.ready;
   assign q_valid      = (count_ff != 2'd0);
   assign q_item       = queue_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

>>> design/slps_seq.sv
// ----------------------------------------------------------------------------
// Status LED pattern sequencer back end
// Holds the request FIFO, the sequencing state and the configuration
// registers, and registers one response per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module slps_seq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  slps_pkg::item_type       q_item,
   input  wire logic                q_valid,
   output logic                     q_pop,
   slps_csr_if.sink                 csr_if,
   slps_rsp_if.source               rsp_if,
   output slps_pkg::seq_status_type status
);
   import slps_pkg::*;

   // Configuration registers.
   ticks_type breath_step_ff, poll_wait_ff;

   // Sequencing state.
   mode_type   mode_ff, mode_in;
   logic       running_ff, running_in;
   step_type   step_ff, step_in;
   ticks_type  timer_ff, timer_in;
   colour_type colour_ff, colour_in;
   logic       refused_ff, refused_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Request FIFO.
   mode_type                fifo_mem [FIFO_DEPTH];
   mode_type                head_mode_ff;
   logic [FIFO_IDX_W-1:0]   head_ff, head_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic [FIFO_CNT_W:0]     wr_sum;
   logic [FIFO_CNT_W:0]     wr_wrap;
   logic [FIFO_IDX_W-1:0]   wr_addr;
   logic                    fifo_wr;
   logic                    fifo_full;

   logic       advance;
   logic       start_seq;
   ticks_type  timer_inc;

   assign csr_if.ready = 1'b1;

   // The back end advances whenever an item is queued and the response slot is free or being taken.
   assign advance = q_valid && (!rsp_valid_ff || rsp_if.ready);
   assign q_pop   = advance;

   assign fifo_full = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));

   // Tail address is head plus count, wrapped once.
   always_comb begin
      wr_sum  = (FIFO_CNT_W + 1)'(head_ff) + (FIFO_CNT_W + 1)'(count_ff);
      wr_wrap = (wr_sum >= (FIFO_CNT_W + 1)'(FIFO_DEPTH)) ?
                wr_sum - (FIFO_CNT_W + 1)'(FIFO_DEPTH) : wr_sum;
      wr_addr = wr_wrap[FIFO_IDX_W-1:0];
   end

   assign timer_inc = (timer_ff == TIMER_MAX) ? timer_ff : timer_ff + 8'd1;

   // Next-state logic for one transaction.
   always_comb begin
      mode_in    = mode_ff;
      running_in = running_ff;
      step_in    = step_ff;
      timer_in   = timer_ff;
      colour_in  = colour_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      refused_in = refused_ff;
      fifo_wr    = 1'b0;
      start_seq  = 1'b0;
      if (advance) begin
         refused_in = 1'b0;
         if (q_item.is_request) begin
            if (!running_ff && count_ff == '0) begin
               // Waiting with an empty FIFO: the request starts at once.
               mode_in   = q_item.mode;
               start_seq = 1'b1;
            end else if (fifo_full) begin
               refused_in = 1'b1;
            end else begin
               fifo_wr  = 1'b1;
               count_in = count_ff + FIFO_CNT_W'(1);
            end
         end else if (!running_ff) begin
            timer_in = timer_inc;
            if (timer_inc >= poll_wait_ff) begin
               start_seq = 1'b1;
            end
         end else if (timer_inc >= seg_len(mode_ff, breath_step_ff)) begin
            timer_in = '0;
            if (last_seg(mode_ff, step_ff)) begin
               step_in = '0;
               if (count_ff != '0) begin
                  // Take the next queued request.
                  mode_in   = head_mode_ff;
                  head_in   = (head_ff == FIFO_IDX_W'(FIFO_DEPTH - 1)) ?
                              '0 : head_ff + FIFO_IDX_W'(1);
                  count_in  = count_ff - FIFO_CNT_W'(1);
                  start_seq = 1'b1;
               end else begin
                  running_in = 1'b0;
                  if (poll_wait_ff == '0) begin
                     start_seq = 1'b1;
                  end
               end
            end else begin
               step_in   = step_ff + 9'd1;
               colour_in = seg_colour(mode_ff, step_ff + 9'd1);
            end
         end else begin
            timer_in = timer_inc;
         end
         if (start_seq) begin
            running_in = 1'b1;
            step_in    = '0;
            timer_in   = '0;
            colour_in  = seg_colour(mode_in, '0);
         end
      end
   end

   // Response slot occupancy.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         breath_step_ff <= BREATH_STEP_RESET;
         poll_wait_ff   <= POLL_WAIT_RESET;
         mode_ff        <= MODE_BOOT;
         running_ff     <= 1'b0;
         step_ff        <= '0;
         timer_ff       <= '0;
         colour_ff      <= COLOUR_OFF;
         head_ff        <= '0;
         count_ff       <= '0;
         refused_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_if.valid && csr_if.index == CSR_BREATH_STEP) begin
            breath_step_ff <= csr_if.data;
         end
         if (csr_if.valid && csr_if.index == CSR_POLL_WAIT) begin
            poll_wait_ff <= csr_if.data;
         end
         mode_ff      <= mode_in;
         running_ff   <= running_in;
         step_ff      <= step_in;
         timer_ff     <= timer_in;
         colour_ff    <= colour_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         refused_ff   <= refused_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // FIFO entries carry no reset; only written entries are ever read.
   // The oldest entry is kept in a register, and a write to the new head
   // address is taken straight into it.
   always_ff @(posedge clock) begin
      if (fifo_wr) begin
         fifo_mem[wr_addr] <= q_item.mode;
      end
      if (fifo_wr && wr_addr == head_in) begin
         head_mode_ff <= q_item.mode;
      end else begin
         head_mode_ff <= fifo_mem[head_in];
      end
   end

   // The colour only moves on an advance, so it holds while stalled.
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.red             = colour_ff.red;
   assign rsp_if.green           = colour_ff.green;
   assign rsp_if.blue            = colour_ff.blue;
   assign rsp_if.request_refused = refused_ff;

   assign status.fifo_count = count_ff;
   assign status.running    = running_ff;

endmodule

`default_nettype wire

>>> design/status_led_pattern_sequencer_top.sv
// ----------------------------------------------------------------------------
// Status LED pattern sequencer
// Plays timed colour patterns for status modes, driven by 1 ms ticks and
// queued mode requests.
//
//   Channel   Direction  Carries
//   req_if    in         op, requested_mode (tick or mode request)
//   rsp_if    out        red, green, blue, request_refused
//   csr_if    in         index, data (breath step, poll wait)
//
// One transaction is taken per cycle, sustained while responses are taken. An
// accepted request is written into the two-entry queue, and the response
// register loads when the sequencer takes it from the queue. The sequencer
// settles one transaction per cycle while its response slot is not stalled.
// Reset is synchronous and leaves the block ready in the next cycle; there
// is no clearing pass. A stalled response stops the sequencer, and the
// queue then fills and drops req_if.ready. Register writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module status_led_pattern_sequencer_top (
   input  wire logic   clock,
   input  wire logic   reset,
   slps_req_if.sink    req_if,
   slps_rsp_if.source  rsp_if,
   slps_csr_if.sink    csr_if
);
   import slps_pkg::*;

   `include "assert_macros.svh"

   item_type       q_item;
   logic           q_valid;
   logic           q_pop;
   seq_status_type seq_status;

   // Front end: accept and classify transactions.
   slps_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_pop   (q_pop)
   );

   // Back end: request FIFO, sequencing and response register.
   slps_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .csr_if  (csr_if),
      .rsp_if  (rsp_if),
      .status  (seq_status)
   );

   // The request FIFO never holds more than its depth.
   `ASSERT_IMPLIES(a_fifo_bound, clock, reset, 1'b1, seq_status.fifo_count <= FIFO_CNT_W'(FIFO_DEPTH), "request FIFO overfilled")

   // A refusal is only reported while the FIFO is full.
   `ASSERT_IMPLIES(a_refused_full, clock, reset, rsp_if.valid && rsp_if.request_refused, seq_status.fifo_count == FIFO_CNT_W'(FIFO_DEPTH), "refusal without full FIFO")

   // Queued requests only exist while a sequence is playing.
   `ASSERT_IMPLIES(a_queue_running, clock, reset, seq_status.fifo_count != '0, seq_status.running, "queued requests while waiting")

   // Taking a transaction into an empty response slot fills it.
   `ASSERT_NEXT(a_pop_fills, clock, reset, q_pop && !rsp_if.valid, rsp_if.valid, "response lost after pop")

endmodule

`default_nettype wire
